### src/hfrc_pkg.sv
// shared types and constants for the hart frame receive checker
`timescale 1ns / 1ps
`default_nettype none

package hfrc_pkg;

	typedef enum logic [2:0] {
		PH_PREAMBLE = 3'd0,
		PH_ADDRESS  = 3'd1,
		PH_COMMAND  = 3'd2,
		PH_COUNT    = 3'd3,
		PH_DATA     = 3'd4,
		PH_CHECKSUM = 3'd5,
		PH_IDLE     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DELIM    = 2'd1,
		ST_FRAMING  = 2'd2,
		ST_CHECKSUM = 2'd3
	} status_t;

	localparam logic [7:0] PREAMBLE_BYTE  = 8'hff;
	localparam logic [7:0] DELIM_BYTE     = 8'h02;
	localparam logic [7:0] ADDR_RSVD_MASK = 8'h30;
	localparam logic [7:0] ADDR_NODE_MASK = 8'h0f;
	localparam logic [3:0] DEV_ADDR_RESET = 4'd2;

	typedef struct packed {
		status_t    status;
		logic       respond;
		logic [7:0] command;
		logic [7:0] data_count;
		logic [3:0] preamble_count;
	} result_t;

endpackage

`default_nettype wire

### src/hart_frame_receive_check.sv
// top level of the hart frame receive checker
// Checks received frames one byte per request on the input channel (rx_byte,
// frame_start). frame_start restarts the parser on that byte. Each frame gives
// one result on the output channel (status, respond, command, data_count,
// preamble_count) when its checksum byte arrives, or at once when a preamble
// beyond MAX_PREAMBLES is seen. Other bytes give no result.
// Throughput: one byte per cycle while in_stall is low; all per-byte work is a single pass of
// logic from the parser state registers to the result register.
// A result is registered when its byte is accepted.
// The result register is backed by a one-entry skid stage, so a byte is still
// accepted while a result waits; in_stall rises only when both are full.
// The device address register is written through cfg_we / cfg_wdata and resets to 2;
// the user must write it only while the block is idle, which the block does not enforce.
// Reset clears the parser to the preamble phase, so a frame may begin
// without frame_start, and empties the output side.
`timescale 1ns / 1ps
`default_nettype none

module hart_frame_receive_check
	import hfrc_pkg::*;
#(
	parameter int MAX_PREAMBLES = 9
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic            respond,
	output logic [7:0]      command,
	output logic [7:0]      data_count,
	output logic [3:0]      preamble_count
);

	localparam logic [3:0] MaxPre = 4'(MAX_PREAMBLES);

	logic [3:0] dev_addr_q;

	phase_t     phase_q, phase_d;
	logic [3:0] pre_q, pre_d;
	logic [7:0] xor_q, xor_d;
	status_t    err_q, err_d;
	logic       match_q, match_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] left_q, left_d;

	phase_t     phase_e;
	logic [3:0] pre_e;
	logic [7:0] xor_e;
	status_t    err_e;
	logic       match_e;
	logic [7:0] cmd_e;
	logic [7:0] cnt_e;
	logic [7:0] left_e;

	logic       emit;
	result_t    res_new;
	result_t    out_q, skid_q;
	logic       out_valid_q, skid_valid_q;
	logic       in_acc, out_take, push;

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid & ~skid_valid_q;
	assign out_take = out_valid_q & ~out_stall;
	assign push     = in_acc & emit;

	// restart view of the parser state
	always_comb begin
		if (frame_start) begin
			phase_e = PH_PREAMBLE;
			pre_e   = '0;
			xor_e   = '0;
			err_e   = ST_OK;
			match_e = 1'b1;
			cmd_e   = '0;
			cnt_e   = '0;
			left_e  = '0;
		end else begin
			phase_e = phase_q;
			pre_e   = pre_q;
			xor_e   = xor_q;
			err_e   = err_q;
			match_e = match_q;
			cmd_e   = cmd_q;
			cnt_e   = cnt_q;
			left_e  = left_q;
		end
	end

	// next state and result
	always_comb begin
		phase_d = phase_e;
		pre_d   = pre_e;
		xor_d   = xor_e;
		err_d   = err_e;
		match_d = match_e;
		cmd_d   = cmd_e;
		cnt_d   = cnt_e;
		left_d  = left_e;
		emit    = 1'b0;
		res_new = '{status: err_e, respond: match_e, command: cmd_e,
			data_count: cnt_e, preamble_count: pre_e};
		case (phase_e)
			PH_PREAMBLE: begin
				if (rx_byte == PREAMBLE_BYTE) begin
					if (pre_e >= MaxPre) begin
						emit    = 1'b1;
						res_new = '{status: ST_FRAMING, respond: 1'b1, command: '0,
							data_count: '0, preamble_count: MaxPre};
						phase_d = PH_IDLE;
					end else begin
						pre_d = pre_e + 4'd1;
					end
				end else begin
					if (rx_byte != DELIM_BYTE) begin
						err_d = ST_DELIM;
					end
					xor_d   = rx_byte;
					phase_d = PH_ADDRESS;
				end
			end
			PH_ADDRESS: begin
				if ((rx_byte & ADDR_RSVD_MASK) != 8'h00) begin
					err_d = ST_FRAMING;
				end
				match_d = ((rx_byte & ADDR_NODE_MASK) == {4'h0, dev_addr_q});
				xor_d   = xor_e ^ rx_byte;
				phase_d = PH_COMMAND;
			end
			PH_COMMAND: begin
				cmd_d   = rx_byte;
				xor_d   = xor_e ^ rx_byte;
				phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				cnt_d   = rx_byte;
				left_d  = rx_byte;
				xor_d   = xor_e ^ rx_byte;
				phase_d = (rx_byte != 8'h00) ? PH_DATA : PH_CHECKSUM;
			end
			PH_DATA: begin
				xor_d  = xor_e ^ rx_byte;
				left_d = left_e - 8'd1;
				if (left_d == 8'h00) begin
					phase_d = PH_CHECKSUM;
				end
			end
			PH_CHECKSUM: begin
				if (rx_byte != xor_e) begin
					err_d = ST_CHECKSUM;
				end
				emit           = 1'b1;
				res_new.status = err_d;
				phase_d        = PH_IDLE;
			end
			default: begin
				phase_d = phase_e;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREAMBLE;
			pre_q   <= '0;
			xor_q   <= '0;
			err_q   <= ST_OK;
			match_q <= 1'b1;
			cmd_q   <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			pre_q   <= pre_d;
			xor_q   <= xor_d;
			err_q   <= err_d;
			match_q <= match_d;
			cmd_q   <= cmd_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign respond        = out_q.respond;
	assign command        = out_q.command;
	assign data_count     = out_q.data_count;
	assign preamble_count = out_q.preamble_count;

endmodule

`default_nettype wire

### src/hfrc_check.sv
// port-level assertions for the hart frame receive checker and their bind
`timescale 1ns / 1ps
`default_nettype none

module hfrc_check #(
	parameter int MAX_PREAMBLES = 9
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status,
	input wire logic       respond,
	input wire logic [7:0] command,
	input wire logic [7:0] data_count,
	input wire logic [3:0] preamble_count
);

	// input side only backs up when a result is already waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// preamble count never exceeds the limit
	a_pre_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(preamble_count) <= MAX_PREAMBLES))
		else $error("preamble count beyond limit");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({status, respond, command, data_count,
			preamble_count}))
		else $error("stalled result changed");

endmodule

bind hart_frame_receive_check hfrc_check #(.MAX_PREAMBLES(MAX_PREAMBLES)) u_hfrc_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.respond        (respond),
	.command        (command),
	.data_count     (data_count),
	.preamble_count (preamble_count)
);

`default_nettype wire

### dv/tb_hart_frame_receive_check.sv
// self-checking testbench for the hart frame receive checker
`timescale 1ns / 1ps

module tb_hart_frame_receive_check;
	import hfrc_pkg::*;

	localparam int MAX_PRE = 9;
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_BYTES = 350;

	typedef struct packed {
		logic [7:0] b;
		logic       s;
		logic       pinned;
		result_t    want;
	} step_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       frame_start;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] status;
	logic       respond;
	logic [7:0] command;
	logic [7:0] data_count;
	logic [3:0] preamble_count;

	hart_frame_receive_check #(.MAX_PREAMBLES(MAX_PRE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.respond(respond),
		.command(command),
		.data_count(data_count),
		.preamble_count(preamble_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser copy
	phase_t     ph;
	logic [3:0] pre_seen;
	logic [7:0] xor_acc;
	status_t    err;
	logic       addr_ok;
	logic [7:0] cmd_hold;
	logic [7:0] cnt_hold;
	logic [7:0] left;
	logic [3:0] dev_addr;

	result_t frames_due[$];
	int      bytes_sent = 0;
	int      frames_checked = 0;
	int      fault_count = 0;
	int      idle_cycles = 0;
	bit      choke_req = 1'b0;
	bit      steady = 1'b0;

	step_row_t script [26] = '{
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{ST_OK, 1'b1, 8'h00, 8'h00, 4'd0}},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'h3f, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hc0, 1'b0, 1'b1, '{ST_FRAMING, 1'b0, 8'hff, 8'h00, 4'd0}},
		'{8'h02, 1'b1, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{ST_CHECKSUM, 1'b1, 8'h80, 8'h00, 4'd0}},
		'{8'hff, 1'b1, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b1, '{ST_FRAMING, 1'b1, 8'h00, 8'h00, 4'd9}}
	};

	function automatic void clear_frame();
		ph = PH_PREAMBLE;
		pre_seen = 4'd0;
		xor_acc = 8'h00;
		err = ST_OK;
		addr_ok = 1'b1;
		cmd_hold = 8'h00;
		cnt_hold = 8'h00;
		left = 8'h00;
	endfunction

	function automatic logic parse_byte(input logic [7:0] b, input logic s, output result_t res);
		res = '0;
		if (s)
			clear_frame();
		case (ph)
			PH_PREAMBLE: begin
				if (b == PREAMBLE_BYTE) begin
					if (pre_seen >= MAX_PRE) begin
						res = '{ST_FRAMING, 1'b1, 8'h00, 8'h00, 4'(MAX_PRE)};
						ph = PH_IDLE;
						return 1'b1;
					end
					pre_seen = pre_seen + 4'd1;
					return 1'b0;
				end
				if (b != DELIM_BYTE)
					err = ST_DELIM;
				xor_acc = b;
				ph = PH_ADDRESS;
			end
			PH_ADDRESS: begin
				if ((b & ADDR_RSVD_MASK) != 8'h00)
					err = ST_FRAMING;
				addr_ok = (b & ADDR_NODE_MASK) == {4'h0, dev_addr};
				xor_acc = xor_acc ^ b;
				ph = PH_COMMAND;
			end
			PH_COMMAND: begin
				cmd_hold = b;
				xor_acc = xor_acc ^ b;
				ph = PH_COUNT;
			end
			PH_COUNT: begin
				cnt_hold = b;
				left = b;
				xor_acc = xor_acc ^ b;
				ph = (b != 8'h00) ? PH_DATA : PH_CHECKSUM;
			end
			PH_DATA: begin
				xor_acc = xor_acc ^ b;
				left = left - 8'd1;
				if (left == 8'h00)
					ph = PH_CHECKSUM;
			end
			PH_CHECKSUM: begin
				if (b != xor_acc)
					err = ST_CHECKSUM;
				res = '{err, addr_ok, cmd_hold, cnt_hold, pre_seen};
				ph = PH_IDLE;
				return 1'b1;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	// one request on the input side, predicted at the edge that takes it
	task automatic send_byte(input logic [7:0] b, input logic s, input logic pinned,
			input result_t want);
		int      gap;
		logic    fired;
		result_t res;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		fired = parse_byte(b, s, res);
		if (pinned)
			frames_due.push_back(want);
		else if (fired)
			frames_due.push_back(res);
		bytes_sent++;
	endtask

	task automatic report_fault(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("result %0d %s: got %0h, expected %0h", frames_checked, what, got, want);
		fault_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				report_fault("with nothing pending", {6'd0, status}, 8'h00);
			end else begin
				want = frames_due.pop_front();
				if (status != want.status)
					report_fault("status", {6'd0, status}, {6'd0, want.status});
				if (respond != want.respond)
					report_fault("respond", {7'd0, respond}, {7'd0, want.respond});
				if (command != want.command)
					report_fault("command", command, want.command);
				if (data_count != want.data_count)
					report_fault("data_count", data_count, want.data_count);
				if (preamble_count != want.preamble_count)
					report_fault("preamble_count", {4'd0, preamble_count},
						{4'd0, want.preamble_count});
			end
			frames_checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("hart_frame_receive_check: mismatch");
			$finish;
		end
	end

	// result side: random hold per request, one long hold on demand
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (choke_req) begin
				hold = 200;
				choke_req = 1'b0;
			end else if (steady) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 4);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int         p;
		int         r;
		int         cnt;
		int         pre_n;
		int         cut;
		int         target;
		logic       lead;
		logic [7:0] x;
		logic [7:0] b;
		logic [7:0] fb[$];
		logic [3:0] addr_plan [4];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		frame_start = 1'b0;
		out_stall = 1'b0;
		dev_addr = DEV_ADDR_RESET;
		clear_frame();
		addr_plan = '{4'h0, 4'hf, 4'($urandom), 4'($urandom)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(script); i++)
			send_byte(script[i].b, script[i].s, script[i].pinned, script[i].want);
		in_valid <= 1'b0;

		for (p = 0; p < 4; p++) begin
			while (frames_due.size() != 0) @(posedge clk);
			repeat (3) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= addr_plan[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			dev_addr = addr_plan[p];
			choke_req = (p == 1);
			steady = (p == 2);
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				r = $urandom_range(0, 99);
				fb.delete();
				lead = $urandom_range(0, 19) != 0;
				if (r < 8) begin
					// noise
					cnt = $urandom_range(1, 6);
					for (int i = 0; i < cnt; i++)
						fb.push_back(8'($urandom));
					lead = 1'($urandom);
					cut = fb.size();
				end else begin
					if (r < 14)
						pre_n = MAX_PRE + 1 + $urandom_range(0, 2);
					else
						pre_n = $urandom_range(0, MAX_PRE);
					repeat (pre_n) fb.push_back(PREAMBLE_BYTE);
					if (pre_n <= MAX_PRE) begin
						x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : DELIM_BYTE;
						fb.push_back(x);
						b = 8'($urandom);
						if ($urandom_range(0, 9) < 7)
							b[5:4] = 2'b00;
						if ($urandom_range(0, 9) < 6)
							b[3:0] = addr_plan[p];
						fb.push_back(b);
						x = x ^ b;
						b = 8'($urandom);
						fb.push_back(b);
						x = x ^ b;
						cnt = $urandom_range(0, 63);
						cnt = (cnt == 0) ? 255 : (cnt < 10) ? 0 : $urandom_range(1, 8);
						fb.push_back(8'(cnt));
						x = x ^ 8'(cnt);
						repeat (cnt) begin
							b = 8'($urandom);
							fb.push_back(b);
							x = x ^ b;
						end
						fb.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : x);
					end
					// cut short now and then
					cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, fb.size()) : fb.size();
				end
				for (int i = 0; i < cut; i++)
					send_byte(fb[i], (i == 0) && lead, 1'b0, '0);
			end
			in_valid <= 1'b0;
		end
		steady = 1'b0;

		while (frames_due.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (fault_count == 0)
			$display("hart_frame_receive_check: match");
		else
			$display("hart_frame_receive_check: mismatch");
		$finish;
	end

endmodule

### hart_frame_receive_check.f
src/hfrc_pkg.sv
src/hart_frame_receive_check.sv
src/hfrc_check.sv
dv/tb_hart_frame_receive_check.sv
